### rtl/core/assert_macros.svh
// assertion macros used by the decode sequencer (rcd_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while in reset
`define RCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication check, held off while in reset
`define RCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/rcd_pkg.sv
// shared types, codes and helpers for the record column decoder
`default_nettype none
package rcd_pkg;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_last;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         column_index;
    logic [2:0]         column_kind;
    logic signed [63:0] column_value;
    logic [7:0]         content_byte;
    logic               content_valid;
    logic               column_done;
    logic               row_done;
    logic [2:0]         row_status;
  } out_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // column kinds
  localparam logic [2:0] KIND_NULL   = 3'd0;
  localparam logic [2:0] KIND_INT    = 3'd1;
  localparam logic [2:0] KIND_REAL   = 3'd2;
  localparam logic [2:0] KIND_TEXT   = 3'd3;
  localparam logic [2:0] KIND_BLOB   = 3'd4;
  localparam logic [2:0] KIND_STATUS = 3'd5;

  // row status codes
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_HDR_BEYOND = 3'd1;
  localparam logic [2:0] STAT_BAD_VARINT = 3'd2;
  localparam logic [2:0] STAT_RESERVED   = 3'd3;
  localparam logic [2:0] STAT_BODY_SHORT = 3'd4;
  localparam logic [2:0] STAT_TOO_MANY   = 3'd5;

  localparam logic [5:0] MAX_RESULTS = 6'd32;

  // body width in bytes of serial types 0..7
  function automatic logic [3:0] ser_width(input logic [2:0] t);
    logic [3:0] w;
    case (t)
      3'd0:    w = 4'd0;
      3'd1:    w = 4'd1;
      3'd2:    w = 4'd2;
      3'd3:    w = 4'd3;
      3'd4:    w = 4'd4;
      3'd5:    w = 4'd6;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

  // sign extension of a big-endian integer of serial type t
  function automatic logic [63:0] int_sext(input logic [63:0] v, input logic [2:0] t);
    logic [63:0] r;
    case (t)
      3'd1:    r = {{56{v[7]}}, v[7:0]};
      3'd2:    r = {{48{v[15]}}, v[15:0]};
      3'd3:    r = {{40{v[23]}}, v[23:0]};
      3'd4:    r = {{32{v[31]}}, v[31:0]};
      3'd5:    r = {{16{v[47]}}, v[47:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/rcd_front.sv
// two-entry input queue in front of the decode sequencer
`default_nettype none
module rcd_front
  import rcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire in_item_t push_item,
  output q_stat_t       stat,
  input  wire logic     pop,
  output in_item_t      head
);

  in_item_t   mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (do_pop) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_item;
  end

endmodule
`default_nettype wire

### rtl/core/rcd_outq.sv
// two-entry result queue behind the decode sequencer
`default_nettype none
module rcd_outq
  import rcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output q_stat_t        stat,
  input  wire logic      pop,
  output out_item_t      head
);

  out_item_t  mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (do_pop) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_item;
  end

endmodule
`default_nettype wire

### rtl/core/rcd_back.sv
// decode sequencer: header varints, type store, body walk and result emission
`default_nettype none
`include "assert_macros.svh"
module rcd_back
  import rcd_pkg::*;
#(
  parameter int MAX_COLUMNS       = 32,
  parameter int MAX_PAYLOAD_BYTES = 67108864
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_stat_t  iq_stat,
  input  wire in_item_t iq_head,
  output logic          iq_pop,
  input  wire q_stat_t  oq_stat,
  output logic          oq_push,
  output out_item_t     oq_item
);

  localparam int PW = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  typedef enum logic [2:0] {
    PH_HSIZE, PH_TYPES, PH_BODY, PH_COMPLETE, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    ST_PROC, ST_OPEN, ST_END, ST_FLUSH
  } seq_t;

  phase_t         ph_r, ph_nxt;
  seq_t           st_r, st_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [63:0]    acc_r, acc_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]  hl_r, hl_nxt;
  logic [CW-1:0]  tw_r, tw_nxt;
  logic [CW-1:0]  cur_r, cur_nxt;
  logic [PW-1:0]  bl_r, bl_nxt;
  logic [63:0]    va_r, va_nxt;
  logic [2:0]     stat_r, stat_nxt;
  logic           last_r, last_nxt;
  logic [5:0]     ecnt_r, ecnt_nxt;
  logic           pend_valid_r, pend_valid_nxt;
  out_item_t      pend_r, pend_nxt;

  logic [31:0]    store [MAX_COLUMNS];
  logic           we;
  logic [31:0]    wdata;

  // step-local signals
  logic           go, last_cur, failed;
  logic [5:0]     ecnt_base;
  logic [7:0]     b;
  logic [63:0]    fa;
  logic           fdone;
  logic [3:0]     fcnt;
  logic [PW-1:0]  pos_inc, blm;
  logic [31:0]    tcur;
  logic [30:0]    len;
  logic [63:0]    va_new;
  logic [6:0]     cur7;
  logic [4:0]     idx, idx_sat;
  logic           emit;
  out_item_t      e_item;

  // type store read at the column cursor
  always_comb begin
    tcur = 32'd0;
    if (cur_r < CW'(MAX_COLUMNS)) tcur = store[cur_r[IW-1:0]];
  end

  assign cur7    = 7'(cur_r);
  assign idx     = cur7[4:0];
  assign idx_sat = (cur7 > 7'd31) ? 5'd31 : cur7[4:0];
  assign b       = iq_head.payload_byte;
  assign go      = !oq_stat.full;

  // varint byte feed
  always_comb begin
    if (cnt_r < 4'd8) begin
      fa    = {acc_r[56:0], b[6:0]};
      fdone = !b[7];
    end else begin
      fa    = {acc_r[55:0], b};
      fdone = 1'b1;
    end
    fcnt = cnt_r + 4'd1;
  end

  assign pos_inc = pos_r + PW'(1);
  assign blm     = (bl_r != '0) ? bl_r - PW'(1) : '0;
  assign va_new  = {va_r[55:0], b};
  assign len     = 31'((tcur - (tcur[0] ? 32'd13 : 32'd12)) >> 1);

  // sequencer next state
  always_comb begin
    ph_nxt         = ph_r;
    st_nxt         = st_r;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    hl_nxt         = hl_r;
    tw_nxt         = tw_r;
    cur_nxt        = cur_r;
    bl_nxt         = bl_r;
    va_nxt         = va_r;
    stat_nxt       = stat_r;
    last_nxt       = last_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    iq_pop         = 1'b0;
    oq_push        = 1'b0;
    oq_item        = '0;
    we             = 1'b0;
    wdata          = '0;
    emit           = 1'b0;
    failed         = 1'b0;
    e_item         = '0;
    e_item.row_status = stat_r;
    last_cur       = last_r;
    ecnt_base      = (st_r == ST_PROC) ? 6'd0 : ecnt_r;
    ecnt_nxt       = ecnt_r;

    unique case (st_r)
      // one payload byte per cycle while a byte is queued and the result queue has room
      ST_PROC: begin
        if (!iq_stat.empty && go) begin
          iq_pop   = 1'b1;
          last_cur = iq_head.payload_last;
          last_nxt = iq_head.payload_last;
          ecnt_nxt = 6'd0;
          st_nxt   = iq_head.payload_last ? ST_END : ST_PROC;
          unique case (ph_r)
            PH_HSIZE: begin
              pos_nxt = pos_inc;
              acc_nxt = fa;
              cnt_nxt = fcnt;
              if (fdone) begin
                acc_nxt = '0;
                cnt_nxt = '0;
                if (fa > 64'(MAX_PAYLOAD_BYTES)) begin
                  failed = 1'b1;
                  e_item.row_status = STAT_HDR_BEYOND;
                end else begin
                  hl_nxt = fa[PW-1:0];
                  ph_nxt = (fa <= 64'(pos_inc)) ? PH_COMPLETE : PH_TYPES;
                end
              end
            end
            PH_TYPES: begin
              pos_nxt = pos_inc;
              acc_nxt = fa;
              cnt_nxt = fcnt;
              if (fdone) begin
                acc_nxt = '0;
                cnt_nxt = '0;
                if (tw_r >= CW'(MAX_COLUMNS)) begin
                  failed = 1'b1;
                  e_item.row_status = STAT_TOO_MANY;
                end else begin
                  we     = 1'b1;
                  wdata  = (fa[63:32] != 32'd0) ? 32'hFFFF_FFFF : fa[31:0];
                  tw_nxt = tw_r + CW'(1);
                end
              end
              if (!failed && pos_inc >= hl_r) begin
                if (!fdone) begin
                  failed = 1'b1;
                  e_item.row_status = STAT_BAD_VARINT;
                end else begin
                  ph_nxt  = PH_BODY;
                  cur_nxt = '0;
                  st_nxt  = ST_OPEN;
                end
              end
            end
            PH_BODY: begin
              if (tcur >= 32'd12) begin
                emit                 = 1'b1;
                e_item.column_index  = idx;
                e_item.column_kind   = tcur[0] ? KIND_TEXT : KIND_BLOB;
                e_item.content_byte  = b;
                e_item.content_valid = 1'b1;
                e_item.column_done   = (bl_r == PW'(1));
              end else begin
                va_nxt = va_new;
              end
              bl_nxt = blm;
              if (blm == '0) begin
                if (tcur < 32'd12) begin
                  emit                = 1'b1;
                  e_item.column_index = idx;
                  e_item.column_kind  = (tcur == 32'd7) ? KIND_REAL : KIND_INT;
                  e_item.column_value = int_sext(va_new, tcur[2:0]);
                  e_item.column_done  = 1'b1;
                end
                cur_nxt = cur_r + CW'(1);
                st_nxt  = ST_OPEN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // one header-only column per cycle while the result queue has room
      ST_OPEN: begin
        if (go) begin
          if (cur_r < tw_r && cur_r < CW'(MAX_COLUMNS)) begin
            if (tcur == 32'd0) begin
              emit                = 1'b1;
              e_item.column_index = idx;
              e_item.column_kind  = KIND_NULL;
              e_item.column_done  = 1'b1;
              cur_nxt             = cur_r + CW'(1);
            end else if (tcur <= 32'd7) begin
              bl_nxt = PW'(ser_width(tcur[2:0]));
              va_nxt = '0;
              st_nxt = last_r ? ST_END : ST_PROC;
            end else if (tcur <= 32'd9) begin
              emit                = 1'b1;
              e_item.column_index = idx;
              e_item.column_kind  = KIND_INT;
              e_item.column_value = 64'(tcur[0]);
              e_item.column_done  = 1'b1;
              cur_nxt             = cur_r + CW'(1);
            end else if (tcur < 32'd12) begin
              failed = 1'b1;
              e_item.row_status = STAT_RESERVED;
              st_nxt = last_r ? ST_END : ST_PROC;
            end else if (len > 31'(MAX_PAYLOAD_BYTES)) begin
              failed = 1'b1;
              e_item.row_status = STAT_BODY_SHORT;
              st_nxt = last_r ? ST_END : ST_PROC;
            end else if (len == 31'd0) begin
              emit                = 1'b1;
              e_item.column_index = idx;
              e_item.column_kind  = tcur[0] ? KIND_TEXT : KIND_BLOB;
              e_item.column_done  = 1'b1;
              cur_nxt             = cur_r + CW'(1);
            end else begin
              bl_nxt = len[PW-1:0];
              st_nxt = last_r ? ST_END : ST_PROC;
            end
          end else begin
            ph_nxt = PH_COMPLETE;
            st_nxt = last_r ? ST_END : ST_PROC;
          end
        end
      end
      // final byte: truncation status or a status-only item
      ST_END: begin
        if (go) begin
          st_nxt = ST_FLUSH;
          if (ph_r == PH_HSIZE) begin
            failed = 1'b1;
            e_item.row_status = STAT_BAD_VARINT;
          end else if (ph_r == PH_TYPES) begin
            failed = 1'b1;
            e_item.row_status = STAT_HDR_BEYOND;
          end else if (ph_r == PH_BODY) begin
            failed = 1'b1;
            e_item.row_status = STAT_BODY_SHORT;
          end else if (ecnt_r == 6'd0) begin
            emit                = 1'b1;
            e_item.column_index = idx_sat;
            e_item.column_kind  = KIND_STATUS;
          end
        end
      end
      // release the held item with row_done and clear the row
      ST_FLUSH: begin
        if (go) begin
          oq_push          = pend_valid_r;
          oq_item          = pend_r;
          oq_item.row_done = 1'b1;
          pend_valid_nxt   = 1'b0;
          st_nxt           = ST_PROC;
          ph_nxt           = PH_HSIZE;
          pos_nxt          = '0;
          acc_nxt          = '0;
          cnt_nxt          = '0;
          hl_nxt           = '0;
          tw_nxt           = '0;
          cur_nxt          = '0;
          bl_nxt           = '0;
          va_nxt           = '0;
          stat_nxt         = STAT_OK;
        end
      end
      default: begin
      end
    endcase

    // error: latch status and emit a status-only item
    if (failed) begin
      stat_nxt            = e_item.row_status;
      ph_nxt              = PH_ERROR;
      emit                = 1'b1;
      e_item.column_index = idx_sat;
      e_item.column_kind  = KIND_STATUS;
    end

    // item delivery, held back one item on the final byte for row_done
    if (emit) begin
      if (ecnt_base < MAX_RESULTS) begin
        ecnt_nxt = ecnt_base + 6'd1;
        if (!last_cur) begin
          oq_push = 1'b1;
          oq_item = e_item;
        end else begin
          oq_push        = pend_valid_r;
          oq_item        = pend_r;
          pend_nxt       = e_item;
          pend_valid_nxt = 1'b1;
        end
      end
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r         <= PH_HSIZE;
      st_r         <= ST_PROC;
      pos_r        <= '0;
      acc_r        <= '0;
      cnt_r        <= '0;
      hl_r         <= '0;
      tw_r         <= '0;
      cur_r        <= '0;
      bl_r         <= '0;
      va_r         <= '0;
      stat_r       <= STAT_OK;
      last_r       <= 1'b0;
      ecnt_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      ph_r         <= ph_nxt;
      st_r         <= st_nxt;
      pos_r        <= pos_nxt;
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      hl_r         <= hl_nxt;
      tw_r         <= tw_nxt;
      cur_r        <= cur_nxt;
      bl_r         <= bl_nxt;
      va_r         <= va_nxt;
      stat_r       <= stat_nxt;
      last_r       <= last_nxt;
      ecnt_r       <= ecnt_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // held item payload
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  // type store write
  always_ff @(posedge clk) begin
    if (we) store[tw_r[IW-1:0]] <= wdata;
  end

  `RCD_ASSERT_IMP(a_no_overflow, oq_push, !oq_stat.full, "result pushed into a full queue")
  `RCD_ASSERT_IMP(a_pop_valid, iq_pop, !iq_stat.empty, "byte taken from an empty queue")
  `RCD_ASSERT_IMP(a_flush_pend, st_r == ST_FLUSH, pend_valid_r, "final byte left no item")
  `RCD_ASSERT_IMP(a_cursor, ph_r == PH_BODY, cur_r <= tw_r, "body walk past stored types")

endmodule
`default_nettype wire

### rtl/core/record_column_decoder_unit.sv
// top level of the record column decoder
//
//   channel   direction  handshake            payload
//   in_       input      in_push / in_full    in_item   (payload byte, last flag)
//   out_      output     out_pop / out_empty  out_item  (one column item)
//
// A byte that ends the header or a column sends the sequencer on to
// look at the next column, opening each null, constant or empty
// text/blob column on the way; the final byte of a row then passes
// through the end and flush states.
// Bytes and results each pass a two-entry queue, so either side may stall
// on its own; the sequencer waits while the result queue is full.
// Reset (rst_n low at a clock edge) empties both queues and clears the row.
`default_nettype none
module record_column_decoder_unit
  import rcd_pkg::*;
#(
  parameter int MAX_COLUMNS       = 32,
  parameter int MAX_PAYLOAD_BYTES = 67108864
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_item,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_item
);

  q_stat_t   iq_stat, oq_stat;
  in_item_t  iq_head;
  logic      iq_pop, oq_push;
  out_item_t oq_item;

  assign in_full   = iq_stat.full;
  assign out_empty = oq_stat.empty;

  // input byte queue
  rcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (in_item),
    .stat      (iq_stat),
    .pop       (iq_pop),
    .head      (iq_head)
  );

  // decode sequencer
  rcd_back #(
    .MAX_COLUMNS       (MAX_COLUMNS),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .iq_stat (iq_stat),
    .iq_head (iq_head),
    .iq_pop  (iq_pop),
    .oq_stat (oq_stat),
    .oq_push (oq_push),
    .oq_item (oq_item)
  );

  // result queue
  rcd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_item (oq_item),
    .stat      (oq_stat),
    .pop       (out_pop),
    .head      (out_item)
  );

endmodule
`default_nettype wire

### sim/record_column_decoder_unit_tb.sv
// testbench for the record column decoder: queue-style driver, monitor and row predictor
`timescale 1ns / 1ps
`default_nettype none
module record_column_decoder_unit_tb;
  import rcd_pkg::*;

  localparam int NCOL = 32;
  localparam int MAX_PAY = 67108864;

  typedef enum logic [2:0] {
    PH_HSIZE, PH_TYPES, PH_BODY, PH_COMPLETE, PH_ERROR
  } phase_e;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_item_t in_item;
  logic out_empty;
  logic out_pop;
  out_item_t out_item;

  record_column_decoder_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  // predictor state
  phase_e      row_phase;
  logic [31:0] byte_pos;
  logic [63:0] vacc;
  int          vcount;
  logic [63:0] hdr_len;
  logic [31:0] col_types [NCOL];
  int          ntypes;
  int          cursor;
  logic [31:0] bytes_left;
  logic [63:0] int_acc;
  logic [2:0]  status;

  in_item_t  byte_queue [$];
  out_item_t column_queue [$];
  out_item_t step_items [$];
  int        errors;
  int        hold_off;
  int        n_bytes;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int ser_bytes(input logic [31:0] t);
    case (t)
      0: return 0; 1: return 1; 2: return 2; 3: return 3;
      4: return 4; 5: return 6; default: return 8;
    endcase
  endfunction

  function automatic void emit(input int idx, input logic [2:0] kind, input logic [63:0] v,
                               input logic [7:0] b, input logic valid, input logic done);
    out_item_t o;
    if (step_items.size() >= NCOL) return;
    o.column_index = idx[4:0];
    o.column_kind = kind;
    o.column_value = v;
    o.content_byte = b;
    o.content_valid = valid;
    o.column_done = done;
    o.row_done = 1'b0;
    o.row_status = status;
    step_items = {step_items, o};
  endfunction

  function automatic void raise(input logic [2:0] code);
    status = code;
    row_phase = PH_ERROR;
    emit(cursor > 31 ? 31 : cursor, KIND_STATUS, 0, 0, 0, 0);
  endfunction

  function automatic bit varint_take(input logic [7:0] b);
    if (vcount < 8) begin
      vacc = (vacc << 7) | b[6:0];
      vcount++;
      return !b[7];
    end
    vacc = (vacc << 8) | b;
    vcount++;
    return 1;
  endfunction

  // emit header-only columns until one needs body bytes
  function automatic void open_cols();
    logic [31:0] t, len;
    while (cursor < ntypes && cursor < NCOL) begin
      t = col_types[cursor];
      if (t == 0) begin
        emit(cursor, KIND_NULL, 0, 0, 0, 1);
        cursor++;
      end else if (t <= 7) begin
        bytes_left = ser_bytes(t);
        int_acc = 0;
        return;
      end else if (t == 8 || t == 9) begin
        emit(cursor, KIND_INT, t - 8, 0, 0, 1);
        cursor++;
      end else if (t < 12) begin
        raise(STAT_RESERVED);
        return;
      end else begin
        len = (t - (t[0] ? 13 : 12)) / 2;
        if (len > MAX_PAY) begin
          raise(STAT_BODY_SHORT);
          return;
        end
        if (len == 0) begin
          emit(cursor, t[0] ? KIND_TEXT : KIND_BLOB, 0, 0, 0, 1);
          cursor++;
        end else begin
          bytes_left = len;
          return;
        end
      end
    end
    row_phase = PH_COMPLETE;
  endfunction

  function automatic void clear_row();
    row_phase = PH_HSIZE;
    byte_pos = 0; vacc = 0; vcount = 0; hdr_len = 0; ntypes = 0;
    cursor = 0; bytes_left = 0; int_acc = 0; status = STAT_OK;
  endfunction

  // predicts the column items caused by one payload byte
  function automatic void decode_byte(input in_item_t it);
    logic [31:0] t;
    logic [63:0] v;
    int w;
    step_items.delete();
    if (row_phase == PH_HSIZE) begin
      byte_pos++;
      if (varint_take(it.payload_byte)) begin
        hdr_len = vacc; vacc = 0; vcount = 0;
        if (hdr_len > MAX_PAY) raise(STAT_HDR_BEYOND);
        else if (hdr_len <= byte_pos) row_phase = PH_COMPLETE;
        else row_phase = PH_TYPES;
      end
    end else if (row_phase == PH_TYPES) begin
      byte_pos++;
      if (varint_take(it.payload_byte)) begin
        v = vacc; vacc = 0; vcount = 0;
        if (ntypes >= NCOL) raise(STAT_TOO_MANY);
        else begin
          col_types[ntypes] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
          ntypes++;
        end
      end
      if (row_phase == PH_TYPES && byte_pos >= hdr_len) begin
        if (vcount != 0) raise(STAT_BAD_VARINT);
        else begin
          row_phase = PH_BODY;
          cursor = 0;
          open_cols();
        end
      end
    end else if (row_phase == PH_BODY) begin
      t = cursor < NCOL ? col_types[cursor] : 0;
      if (t >= 12) emit(cursor, t[0] ? KIND_TEXT : KIND_BLOB, 0, it.payload_byte, 1,
                        bytes_left == 1);
      else int_acc = (int_acc << 8) | it.payload_byte;
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) begin
        if (t < 12) begin
          v = int_acc;
          w = ser_bytes({29'd0, t[2:0]});
          if (t <= 6 && w >= 1 && w < 8 && v[8*w-1]) v |= ~((64'd1 << (8*w)) - 1);
          emit(cursor, t == 7 ? KIND_REAL : KIND_INT, v, 0, 0, 1);
        end
        cursor++;
        open_cols();
      end
    end
    if (it.payload_last) begin
      if (row_phase == PH_HSIZE) raise(STAT_BAD_VARINT);
      else if (row_phase == PH_TYPES) raise(STAT_HDR_BEYOND);
      else if (row_phase == PH_BODY) raise(STAT_BODY_SHORT);
      if (step_items.size() == 0) emit(cursor > 31 ? 31 : cursor, KIND_STATUS, 0, 0, 0, 0);
      step_items[step_items.size()-1].row_done = 1'b1;
      clear_row();
    end
    column_queue = {column_queue, step_items};
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver: one transfer per handshake, random gap after each
  int gap;
  in_item_t cur;
  initial begin
    in_push = 0; in_item = '0; gap = 0;
  end
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 0;
    end else if (in_push && !in_full) begin
      decode_byte(in_item);
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap == 0 && byte_queue.size() > 0) begin
        cur = byte_queue.pop_front();
        in_item <= cur;
      end else begin
        in_push <= 0;
      end
    end else if (!in_push) begin
      if (gap > 0) gap--;
      else if (byte_queue.size() > 0) begin
        cur = byte_queue.pop_front();
        in_item <= cur;
        in_push <= 1;
      end
    end
  end

  // receiver stall and long hold-off
  int pop_wait;
  initial out_pop = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 0; pop_wait = 0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_pop <= 0;
    end else if (out_pop && !out_empty) begin
      pop_wait = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) pop_wait = 0;
      out_pop <= (pop_wait == 0);
    end else if (pop_wait > 0) begin
      pop_wait--;
      out_pop <= (pop_wait == 0);
    end else begin
      out_pop <= 1;
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  out_item_t exp_item;
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (column_queue.size() == 0) report("result with nothing predicted");
      else begin
        exp_item = column_queue.pop_front();
        if (out_item.column_index !== exp_item.column_index)
          report($sformatf("column_index %0d exp %0d", out_item.column_index,
                           exp_item.column_index));
        if (out_item.column_kind !== exp_item.column_kind)
          report($sformatf("column_kind %0d exp %0d", out_item.column_kind,
                           exp_item.column_kind));
        if (out_item.column_value !== exp_item.column_value)
          report($sformatf("column_value %h exp %h", out_item.column_value,
                           exp_item.column_value));
        if (out_item.content_byte !== exp_item.content_byte)
          report($sformatf("content_byte %h exp %h", out_item.content_byte,
                           exp_item.content_byte));
        if (out_item.content_valid !== exp_item.content_valid) report("content_valid");
        if (out_item.column_done !== exp_item.column_done) report("column_done");
        if (out_item.row_done !== exp_item.row_done) report("row_done");
        if (out_item.row_status !== exp_item.row_status)
          report($sformatf("row_status %0d exp %0d", out_item.row_status,
                           exp_item.row_status));
      end
    end
  end

  // stimulus helpers
  task automatic add_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.payload_byte = b;
    it.payload_last = last;
    byte_queue = {byte_queue, it};
    n_bytes++;
  endtask

  // a byte array to a payload with the last flag on the final byte
  task automatic add_row(input logic [7:0] bytes [$]);
    foreach (bytes[i]) add_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // header with random types plus random body of the right size (maybe cut short or with an extra byte)
  task automatic random_row(input int ncols, input bit cut, input bit bad_types);
    logic [7:0] hdr [$];
    logic [7:0] body [$];
    logic [7:0] row [$];
    int t, len;
    for (int c = 0; c < ncols; c++) begin
      case ($urandom_range(0, 9))
        0: t = $urandom_range(0, 9);
        1, 2, 3: t = $urandom_range(1, 7);
        4, 5: t = 12 + $urandom_range(0, 10);
        6, 7: t = 13 + $urandom_range(0, 10);
        8: t = bad_types ? $urandom_range(10, 11) : 8;
        default: t = 12 + 2 * $urandom_range(0, 80) + $urandom_range(0, 1);
      endcase
      // type varint, big-endian
      if (t >= 128) begin
        hdr = {hdr, 8'(8'h80 | (t >> 7)), 8'(t & 8'h7F)};
      end else hdr = {hdr, 8'(t)};
      if (t >= 12) len = (t - (t % 2 ? 13 : 12)) / 2;
      else if (t >= 1 && t <= 7) len = ser_bytes(t);
      else len = 0;
      for (int k = 0; k < len; k++) body = {body, 8'($urandom_range(0, 255))};
    end
    row = {8'(hdr.size() + 1), hdr, body};
    if (cut && row.size() > 2) row = row[0:$urandom_range(0, row.size() - 2)];
    else if ($urandom_range(0, 5) == 0) row = {row, 8'($urandom_range(0, 255))};
    add_row(row);
  endtask

  initial begin
    errors = 0; hold_off = 0; n_bytes = 0;
    clear_row();
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // directed: text, blob, reserved types, truncation and limit cases
    add_row('{8'd3, 8'd15, 8'd14, 8'h41, 8'hFF, 8'h00}); // text then blob
    add_row('{8'd2, 8'd10, 8'h00});                       // reserved type
    add_row('{8'd2, 8'd11});
    add_row('{8'd1, 8'h55, 8'hAA});                       // header only, extra bytes
    add_row('{8'd0});                                     // header size too small
    add_row('{8'h81});                                    // ends inside size varint
    add_row('{8'd5, 8'd1});                               // ends inside header
    add_row('{8'd3, 8'h81, 8'h80});                       // type varint cut by header end
    add_row('{8'd3, 8'd1, 8'd1});                         // body short
    add_row('{8'h84, 8'h80, 8'h80, 8'h81, 8'h00});        // header above limit
    // nine-byte type varint above 32 bits, saturated then body short
    add_row('{8'd11, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    // too many columns
    add_byte(8'd35, 0);
    for (int i = 0; i < 33; i++) add_byte(8'd0, 0);
    add_byte(8'd0, 1);
    // blob longer than limit
    add_row('{8'd6, 8'h88, 8'h80, 8'h80, 8'h80, 8'h0C, 8'h00});

    // long receiver hold-off while bytes keep coming: one byte opens 32 nulls
    wait (byte_queue.size() == 0);
    hold_off = 200;
    add_byte(8'd33, 0);
    for (int i = 0; i < 31; i++) add_byte(8'd0, 0);
    add_byte(8'd0, 1);
    // integer, real, constants, null and empty blob types; body one byte short
    add_row('{8'd8, 8'd1, 8'd6, 8'd7, 8'd0, 8'd8, 8'd9, 8'd12,
              8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    add_row('{8'd5, 8'd2, 8'd3, 8'd4, 8'd5, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00,
              8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});

    // random rows until about the byte budget
    while (n_bytes < 170) begin
      case ($urandom_range(0, 9))
        0: random_row($urandom_range(1, 4), 1, 1);
        1: random_row($urandom_range(1, 3), 0, 1);
        default: random_row($urandom_range(1, 3), 0, 0);
      endcase
    end

    wait (byte_queue.size() == 0 && !in_push);
    wait (column_queue.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && column_queue.size() == 0) $display("record_column_decoder_unit: match");
    else begin
      if (column_queue.size() != 0) report("predicted results never arrived");
      $display("record_column_decoder_unit: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("record_column_decoder_unit: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
